// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Stands alone: it needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle, held off while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent, held off while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lphm_pkg.sv =====
// Shared constants, entry layout and hash unit interface types for the hash map.
// No dependencies; lphm_mix, the hash map top and its checker refer to it by scoped names.
package lphm_pkg;

    // The slot count is a power of two, so the home slot is the low bits of the hash.
    localparam int SLOT_W      = 12;
    localparam int TABLE_SLOTS = 1 << SLOT_W;
    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 12;
    localparam int HALF_W      = KEY_W / 2;
    localparam int MIX_SHIFT   = 33;

    localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [KEY_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;

    // One table entry as held in the slot memory.
    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Request to the hash unit.
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
    } t_mix_req;

    // Response from the hash unit.
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] home;
    } t_mix_rsp;

endpackage

// ===== design/lphm_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// Stands alone: width and depth come in as parameters.
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: either a write or a read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lphm_mix.sv =====
// Multi-cycle 64-bit key mixer that yields the home slot of a key.
// Depends on lphm_pkg; each 64-bit product is built from three 32x32 partial products.
module lphm_mix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lphm_pkg::t_mix_req i_req,
    output lphm_pkg::t_mix_rsp o_rsp
);

    typedef enum logic [2:0] {
        MIX_IDLE,
        MIX_LO,
        MIX_CROSS_A,
        MIX_CROSS_B,
        MIX_SUM
    } t_mix_state;

    t_mix_state                     r_state;
    logic                           r_round;
    logic                           r_done;
    logic [lphm_pkg::KEY_W-1:0]     r_x;
    logic [lphm_pkg::KEY_W-1:0]     r_p0;
    logic [lphm_pkg::HALF_W-1:0]    r_cross;

    logic [lphm_pkg::KEY_W-1:0]     w_const;
    logic [lphm_pkg::HALF_W-1:0]    w_op_a;
    logic [lphm_pkg::HALF_W-1:0]    w_op_b;
    logic [lphm_pkg::KEY_W-1:0]     w_prod;
    logic [lphm_pkg::KEY_W-1:0]     w_sum;
    logic [lphm_pkg::KEY_W-1:0]     n_x;

    // Operand selection for the shared 32x32 multiplier.
    always_comb begin
        w_const = r_round ? lphm_pkg::MIX_MUL_B : lphm_pkg::MIX_MUL_A;
        w_op_a  = (r_state == MIX_CROSS_B) ? r_x[lphm_pkg::KEY_W-1:lphm_pkg::HALF_W]
                                           : r_x[lphm_pkg::HALF_W-1:0];
        w_op_b  = (r_state == MIX_CROSS_A) ? w_const[lphm_pkg::KEY_W-1:lphm_pkg::HALF_W]
                                           : w_const[lphm_pkg::HALF_W-1:0];
        w_prod  = lphm_pkg::KEY_W'(w_op_a) * lphm_pkg::KEY_W'(w_op_b);
        // The low 64 bits of the full product, followed by the xor-shift.
        w_sum   = r_p0 + {r_cross, {lphm_pkg::HALF_W{1'b0}}};
        n_x     = w_sum ^ (w_sum >> lphm_pkg::MIX_SHIFT);
    end

    // Sequencer: two rounds of low product, two cross products and a final sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MIX_IDLE;
            r_done  <= 1'b0;
            r_round <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                MIX_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= i_req.key ^ (i_req.key >> lphm_pkg::MIX_SHIFT);
                        r_round <= 1'b0;
                        r_state <= MIX_LO;
                    end
                end
                MIX_LO: begin
                    r_p0    <= w_prod;
                    r_state <= MIX_CROSS_A;
                end
                MIX_CROSS_A: begin
                    r_cross <= w_prod[lphm_pkg::HALF_W-1:0];
                    r_state <= MIX_CROSS_B;
                end
                MIX_CROSS_B: begin
                    r_cross <= r_cross + w_prod[lphm_pkg::HALF_W-1:0];
                    r_state <= MIX_SUM;
                end
                MIX_SUM: begin
                    r_x <= n_x;
                    if (r_round) begin
                        r_done  <= 1'b1;
                        r_state <= MIX_IDLE;
                    end else begin
                        r_round <= 1'b1;
                        r_state <= MIX_LO;
                    end
                end
                default: begin
                    r_state <= MIX_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.home = r_x[lphm_pkg::SLOT_W-1:0];

endmodule

// ===== design/linear_probe_hash_map.sv =====
// Open-addressing hash map from a 64-bit key to a 12-bit index, with linear probing.
// One request (insert or lookup) is taken at a time. After acceptance the key mixer
// computes the home slot, the first slot is read, then each probe is one read of
// the single-port slot memory, and the result is then loaded into the output
// register. A request may be accepted while the previous result still waits in the
// output register. After reset the block clears the slot memory, one slot a cycle,
// and stalls its input until that is done.
// Depends on lphm_pkg, lphm_ram and lphm_mix.
module linear_probe_hash_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic signed [lphm_pkg::KEY_W-1:0] i_key,
    input  logic [lphm_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [lphm_pkg::VALUE_W-1:0]  o_stored_index,
    output logic                          o_table_full
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FINISH
    } t_state;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic [lphm_pkg::SLOT_W-1:0] LAST_SLOT =
        lphm_pkg::SLOT_W'(lphm_pkg::TABLE_SLOTS - 1);
    localparam logic [lphm_pkg::SLOT_W:0] PROBE_LIMIT =
        (lphm_pkg::SLOT_W + 1)'(lphm_pkg::TABLE_SLOTS);

    t_state                          r_state;
    logic [lphm_pkg::SLOT_W-1:0]     r_clr;
    logic                            r_kind;
    logic [lphm_pkg::KEY_W-1:0]      r_key;
    logic [lphm_pkg::VALUE_W-1:0]    r_value;
    logic [lphm_pkg::SLOT_W-1:0]     r_pos;
    logic [lphm_pkg::SLOT_W:0]       r_probes;
    logic                            r_res_found;
    logic [lphm_pkg::VALUE_W-1:0]    r_res_idx;
    logic                            r_res_full;
    logic                            r_out_valid;
    logic                            r_out_found;
    logic [lphm_pkg::VALUE_W-1:0]    r_out_idx;
    logic                            r_out_full;

    logic                            w_in_accept;
    lphm_pkg::t_mix_req              w_mix_req;
    lphm_pkg::t_mix_rsp              w_mix_rsp;
    logic                            w_ram_en;
    logic                            w_ram_we;
    logic [lphm_pkg::SLOT_W-1:0]     w_ram_addr;
    lphm_pkg::t_entry                w_wr_entry;
    logic [lphm_pkg::ENTRY_W-1:0]    w_ram_rdata;
    lphm_pkg::t_entry                w_rd;
    logic [lphm_pkg::SLOT_W:0]       n_probes;
    logic                            w_free;
    logic                            w_hit;
    logic                            w_exhausted;
    logic                            w_stop;
    logic                            w_res_found;
    logic [lphm_pkg::VALUE_W-1:0]    w_res_idx;
    logic                            w_res_full;

    assign w_in_accept = i_in_valid && (r_state == ST_IDLE);

    // Key mixer.
    assign w_mix_req.start = w_in_accept;
    assign w_mix_req.key   = unsigned'(i_key);

    lphm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mix_req),
        .o_rsp   (w_mix_rsp)
    );

    // Slot memory: used flag, key and value of every slot in one word.
    lphm_ram #(
        .WIDTH (lphm_pkg::ENTRY_W),
        .DEPTH (lphm_pkg::TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_wr_entry),
        .o_rdata (w_ram_rdata)
    );

    // Examination of the slot read in the previous cycle.
    always_comb begin
        w_rd        = w_ram_rdata;
        n_probes    = r_probes + 1'b1;
        w_free      = !w_rd.used;
        w_hit       = w_rd.used && (w_rd.key == r_key);
        w_exhausted = (n_probes == PROBE_LIMIT);
        w_stop      = w_free || w_hit || w_exhausted;

        // A full-table insert and a missed lookup both leave found and index at zero.
        w_res_found = w_hit;
        w_res_full  = 1'b0;
        w_res_idx   = '0;
        if (r_kind == KIND_INSERT) begin
            if (w_free || w_hit) begin
                w_res_idx = r_value;
            end else begin
                w_res_full = 1'b1;
            end
        end else if (w_hit) begin
            w_res_idx = w_rd.value;
        end
    end

    // Memory port: clearing pass, first read, probe reads and the final write.
    always_comb begin
        w_ram_en         = 1'b0;
        w_ram_we         = 1'b0;
        w_ram_addr       = r_pos;
        w_wr_entry.used  = 1'b1;
        w_wr_entry.key   = r_key;
        w_wr_entry.value = r_value;
        case (r_state)
            ST_CLEAR: begin
                w_ram_en   = 1'b1;
                w_ram_we   = 1'b1;
                w_ram_addr = r_clr;
                w_wr_entry = '0;
            end
            ST_HASH: begin
                w_ram_en   = w_mix_rsp.done;
                w_ram_addr = w_mix_rsp.home;
            end
            ST_PROBE: begin
                if (w_stop) begin
                    w_ram_en = (r_kind == KIND_INSERT) && (w_free || w_hit);
                    w_ram_we = 1'b1;
                end else begin
                    w_ram_en   = 1'b1;
                    w_ram_addr = r_pos + 1'b1;
                end
            end
            default: begin
                w_ram_en = 1'b0;
            end
        endcase
    end

    // Request sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills from a finished request and empties on a taken beat.
            if ((r_state == ST_FINISH) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_SLOT) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_in_accept) begin
                        r_kind  <= i_kind;
                        r_key   <= unsigned'(i_key);
                        r_value <= i_value;
                        r_state <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    if (w_mix_rsp.done) begin
                        r_pos    <= w_mix_rsp.home;
                        r_probes <= '0;
                        r_state  <= ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    if (w_stop) begin
                        r_res_found <= w_res_found;
                        r_res_idx   <= w_res_idx;
                        r_res_full  <= w_res_full;
                        r_state     <= ST_FINISH;
                    end else begin
                        r_pos    <= r_pos + 1'b1;
                        r_probes <= n_probes;
                    end
                end
                ST_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_found <= r_res_found;
                        r_out_idx   <= r_res_idx;
                        r_out_full  <= r_res_full;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_stored_index = r_out_idx;
    assign o_table_full   = r_out_full;

endmodule

// ===== design/lphm_checker.sv =====
// Port-level assertions for the hash map, attached to the top level by a bind.
// Depends on assert_macros.svh and lphm_pkg.
`include "assert_macros.svh"

module lphm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_kind,
    input logic signed [lphm_pkg::KEY_W-1:0] i_key,
    input logic [lphm_pkg::VALUE_W-1:0]  i_value,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_found,
    input logic [lphm_pkg::VALUE_W-1:0]  o_stored_index,
    input logic                          o_table_full
);

    logic w_in_beat;

    assign w_in_beat = i_in_valid && !o_in_stall;

    // A stalled result beat holds.
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_found) && $stable(o_stored_index) && $stable(o_table_full), "stalled result beat changed")

    // A full-table report carries neither a hit nor an index.
    `ASSERT_IMP(a_full_clean, i_clk, i_rst_n, o_out_valid && o_table_full, !o_found && (o_stored_index == '0), "full table result with hit or index")

    // Only one request is in flight: the input closes after a beat.
    `ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, w_in_beat, o_in_stall, "input accepted twice in a row")

    // A result needs hashing and probing, so it cannot appear straight after a beat.
    `ASSERT_NXT(a_no_instant_result, i_clk, i_rst_n, w_in_beat, !$rose(o_out_valid), "result rose one cycle after request")

    // The key and value are not checked further; they only travel with the request.
    logic w_unused;
    assign w_unused = i_kind ^ (^i_key) ^ (^i_value);

endmodule

bind linear_probe_hash_map lphm_checker u_checker (.*);

// ===== tb/sv/lphm_tb_pkg.sv =====
`timescale 1ns / 100ps
// Request codes, the result layout and the shadow copy of the hash map used for checking.
// Depends on lphm_pkg for the table size, field widths and mixing constants.
package lphm_tb_pkg;

    // Request kinds as carried on i_kind.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_e;

    // One result beat as it should leave the block.
    typedef struct packed {
        logic                          found;
        logic [lphm_pkg::VALUE_W-1:0]  stored;
        logic                          full;
    } result_t;

    // Shadow table: predicts each result and checks the block's results in order.
    class hash_map_mirror;
        bit                           slot_taken [lphm_pkg::TABLE_SLOTS];
        logic [lphm_pkg::KEY_W-1:0]   slot_keys  [lphm_pkg::TABLE_SLOTS];
        logic [lphm_pkg::VALUE_W-1:0] slot_vals  [lphm_pkg::TABLE_SLOTS];
        int unsigned                  fill_count;
        int unsigned                  mismatches;
        result_t                      pending_results [$];

        function new();
            foreach (slot_taken[i]) begin
                slot_taken[i] = 1'b0;
                slot_keys[i]  = '0;
                slot_vals[i]  = '0;
            end
            fill_count = 0;
            mismatches = 0;
        endfunction

        // Three xor-shift rounds with two multiplies; the home slot is the low bits.
        function int home_of(input logic [lphm_pkg::KEY_W-1:0] key);
            logic [lphm_pkg::KEY_W-1:0] x;
            x = key;
            x = x ^ (x >> lphm_pkg::MIX_SHIFT);
            x = x * lphm_pkg::MIX_MUL_A;
            x = x ^ (x >> lphm_pkg::MIX_SHIFT);
            x = x * lphm_pkg::MIX_MUL_B;
            x = x ^ (x >> lphm_pkg::MIX_SHIFT);
            return int'(x[lphm_pkg::SLOT_W-1:0]);
        endfunction

        // Walks from the home slot and returns the first slot that is free or holds the
        // key, or -1 when a full sweep of the table meets neither.
        function int locate(input logic [lphm_pkg::KEY_W-1:0] key);
            int pos;
            pos = home_of(key);
            for (int n = 0; n < lphm_pkg::TABLE_SLOTS; n++) begin
                if (!slot_taken[pos] || slot_keys[pos] == key) begin
                    return pos;
                end
                pos = (pos == lphm_pkg::TABLE_SLOTS - 1) ? 0 : pos + 1;
            end
            return -1;
        endfunction

        function bit holds(input logic [lphm_pkg::KEY_W-1:0] key);
            int pos;
            pos = locate(key);
            return (pos >= 0) && slot_taken[pos];
        endfunction

        // Updates the shadow table for an accepted request and queues its result.
        function void apply_request(input op_e op, input logic [lphm_pkg::KEY_W-1:0] key,
                                    input logic [lphm_pkg::VALUE_W-1:0] val);
            result_t r;
            int      pos;
            r   = '0;
            pos = locate(key);
            if (op == OP_INSERT) begin
                if (pos < 0) begin
                    r.full = 1'b1;
                end else begin
                    r.found = slot_taken[pos];
                    if (!slot_taken[pos]) begin
                        fill_count++;
                    end
                    slot_taken[pos] = 1'b1;
                    slot_keys[pos]  = key;
                    slot_vals[pos]  = val;
                    r.stored        = val;
                end
            end else if (pos >= 0 && slot_taken[pos]) begin
                r.found  = 1'b1;
                r.stored = slot_vals[pos];
            end
            pending_results.push_back(r);
        endfunction

        // Compares a result beat with the oldest outstanding prediction.
        function void check_result(input result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat: found=%0d index=%0d full=%0d",
                             got.found, got.stored, got.full);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found || got.stored !== want.stored
                    || got.full !== want.full) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected found=%0d index=%0d full=%0d, got found=%0d index=%0d full=%0d",
                             want.found, want.stored, want.full,
                             got.found, got.stored, got.full);
                end
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function int unsigned occupancy();
            return fill_count;
        endfunction

        function int unsigned failures();
            return mismatches;
        endfunction
    endclass

endpackage

// ===== tb/sv/linear_probe_hash_map_tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench for linear_probe_hash_map: drives requests, checks every result.
// Depends on lphm_pkg, lphm_tb_pkg and the hash map RTL.
module linear_probe_hash_map_tb;
    import lphm_tb_pkg::*;

    localparam int SLOTS        = lphm_pkg::TABLE_SLOTS;
    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_LIMIT  = 4 * (SLOTS + 1024);
    localparam int DRAIN_CYCLES = 64;

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_in_valid     = 1'b0;
    logic                                i_kind         = 1'b0;
    logic signed [lphm_pkg::KEY_W-1:0]   i_key          = '0;
    logic [lphm_pkg::VALUE_W-1:0]        i_value        = '0;
    logic                                i_out_stall    = 1'b0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic                                o_found;
    logic [lphm_pkg::VALUE_W-1:0]        o_stored_index;
    logic                                o_table_full;

    int unsigned                         send_idle_pct  = 10;
    int unsigned                         recv_idle_pct  = 71;
    int unsigned                         quiet_cycles   = 0;
    logic [lphm_pkg::KEY_W-1:0]          known_keys [$];
    hash_map_mirror                      mirror         = new();

    linear_probe_hash_map u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_stored_index (o_stored_index),
        .o_table_full   (o_table_full)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: check each accepted beat, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            mirror.check_result('{found: o_found, stored: o_stored_index,
                                  full: o_table_full});
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("linear_probe_hash_map_tb: done, errors");
            $finish;
        end
    end

    // A random key that the table does not hold, with its home slot at or above lowest_home.
    function automatic logic [lphm_pkg::KEY_W-1:0] fresh_key(input int lowest_home);
        logic [lphm_pkg::KEY_W-1:0] k;
        do begin
            k = {$urandom, $urandom};
        end while (mirror.holds(k) || mirror.home_of(k) < lowest_home);
        return k;
    endfunction

    function automatic logic [lphm_pkg::VALUE_W-1:0] random_value();
        return lphm_pkg::VALUE_W'($urandom_range(0, (1 << lphm_pkg::VALUE_W) - 1));
    endfunction

    function automatic logic [lphm_pkg::KEY_W-1:0] pick_known();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    // Presents one request beat after an optional idle gap and waits until it is taken.
    task automatic send_request(input op_e op, input logic [lphm_pkg::KEY_W-1:0] key,
                                input logic [lphm_pkg::VALUE_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= op;
        i_key      <= key;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        mirror.apply_request(op, key, val);
    endtask

    // Inserts a key the table does not hold and remembers it for later hits.
    task automatic insert_new(input int lowest_home);
        logic [lphm_pkg::KEY_W-1:0] k;
        k = fresh_key(lowest_home);
        send_request(OP_INSERT, k, random_value());
        known_keys.push_back(k);
    endtask

    // One random request: new inserts, updates and lookups of stored keys, and misses.
    // Some keys are drawn to home near the top of the table so that probes wrap round.
    task automatic random_request();
        int pick;
        int lowest;
        pick   = $urandom_range(0, 99);
        lowest = ($urandom_range(0, 4) == 0) ? SLOTS - 16 : 0;
        if (pick < 35) begin
            insert_new(lowest);
        end else if (pick < 50) begin
            send_request(OP_INSERT, pick_known(), random_value());
        end else if (pick < 80) begin
            send_request(OP_LOOKUP, pick_known(), random_value());
        end else begin
            send_request(OP_LOOKUP, fresh_key(lowest), random_value());
        end
    endtask

    initial begin
        logic [lphm_pkg::KEY_W-1:0] wrap_key [4];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme keys and values on an empty table, then an update.
        send_request(OP_LOOKUP, 64'h0, '1);
        send_request(OP_INSERT, 64'h0, '0);
        send_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, '1);
        send_request(OP_INSERT, 64'h8000_0000_0000_0000, 12'd1);
        send_request(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 12'd4094);
        known_keys.push_back(64'h0);
        known_keys.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        known_keys.push_back(64'h8000_0000_0000_0000);
        known_keys.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        send_request(OP_LOOKUP, 64'h0, '0);
        send_request(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_request(OP_INSERT, 64'h8000_0000_0000_0000, '1);
        send_request(OP_LOOKUP, 64'h8000_0000_0000_0000, '0);

        // Directed: keys sharing the last home slot force the probe to wrap to slot 0.
        for (int i = 0; i < 3; i++) begin
            wrap_key[i] = fresh_key(SLOTS - 1);
            send_request(OP_INSERT, wrap_key[i], random_value());
            known_keys.push_back(wrap_key[i]);
        end
        wrap_key[3] = fresh_key(SLOTS - 1);
        send_request(OP_LOOKUP, wrap_key[2], random_value());
        send_request(OP_INSERT, wrap_key[2], random_value());
        send_request(OP_LOOKUP, wrap_key[3], random_value());
        send_request(OP_INSERT, wrap_key[3], random_value());
        known_keys.push_back(wrap_key[3]);
        send_request(OP_LOOKUP, wrap_key[3], random_value());
        send_request(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, random_value());
        send_request(OP_LOOKUP, fresh_key(0), random_value());

        // Random traffic in three idling regimes: sender light, receiver light, none.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 10 : 0;
            repeat (RANDOM_ITEMS / 3) begin
                random_request();
            end
        end

        // Fill every slot, then show the full-table behaviour of inserts and lookups.
        while (mirror.occupancy() < SLOTS) begin
            insert_new(0);
        end
        send_request(OP_INSERT, fresh_key(0), random_value());
        send_request(OP_INSERT, fresh_key(SLOTS - 1), random_value());
        send_request(OP_INSERT, pick_known(), random_value());
        send_request(OP_LOOKUP, fresh_key(0), random_value());
        repeat (8) begin
            send_request(OP_LOOKUP, pick_known(), random_value());
        end
        send_request(OP_INSERT, wrap_key[3], '0);
        send_request(OP_LOOKUP, wrap_key[3], '1);

        // Drain: wait for every outstanding result, then watch for stray beats.
        i_in_valid <= 1'b0;
        while (mirror.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mirror.failures() == 0 && mirror.outstanding() == 0) begin
            $display("linear_probe_hash_map_tb: done, clean");
        end else begin
            $display("linear_probe_hash_map_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== linear_probe_hash_map.f =====
+incdir+design
design/lphm_pkg.sv
design/lphm_ram.sv
design/lphm_mix.sv
design/linear_probe_hash_map.sv
design/lphm_checker.sv
tb/sv/lphm_tb_pkg.sv
tb/sv/linear_probe_hash_map_tb.sv
